// File: rtl/core/selective_gram_schmidt_top_macros.svh
// Assertion macros shared by the selective Gram-Schmidt RTL
`ifndef SELECTIVE_GRAM_SCHMIDT_TOP_MACROS_SVH
`define SELECTIVE_GRAM_SCHMIDT_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SGS_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SGS_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sgs_pkg.sv
// Shared constants, types and helpers for the selective Gram-Schmidt block
`default_nettype none

package sgs_pkg;

    localparam int DIM_MAX    = 8;
    localparam int FRAC_BITS  = 24;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(DIM_MAX);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int DIM_W      = 4;
    localparam int DIV_W      = DATA_W + FRAC_BITS;
    localparam int SQRT_STEPS = 32;
    localparam int CNT_W      = $clog2(DIV_W + 1);

    typedef enum logic [0:0] {
        OP_SQRT = 1'b0,
        OP_DIV  = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (x > hi) begin
            sat32 = DATA_W'(hi);
        end else if (x < lo) begin
            sat32 = DATA_W'(lo);
        end else begin
            sat32 = DATA_W'(x);
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sgs_mul.sv
// Shared registered signed 32x32 multiplier
`default_nettype none

module sgs_mul
    import sgs_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic signed [DATA_W-1:0]   mul_a,
    input  wire logic signed [DATA_W-1:0]   mul_b,
    output logic signed [2*DATA_W-1:0]      mul_p
);

    logic signed [2*DATA_W-1:0] prod_reg;

    // one product per cycle, result registered into the next cycle
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign mul_p = prod_reg;

endmodule

`default_nettype wire

// File: rtl/core/sgs_arith.sv
// Iterative unit: 64-bit integer square root and unsigned long division
`default_nettype none
`include "selective_gram_schmidt_top_macros.svh"

module sgs_arith
    import sgs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire arith_req_t         req,
    input  wire logic [63:0]        op_a,
    input  wire logic [DATA_W-1:0]  op_b,
    output logic                    done,
    output logic [63:0]             result
);

    logic             busy_reg;
    logic             done_reg;
    arith_op_t        op_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [63:0]      x_reg;
    logic [63:0]      r_reg;
    logic [63:0]      bit_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] d_reg;

    logic [63:0]      sq_trial;
    logic [DATA_W:0]  rem_sh;
    logic             div_ge;

    // one root bit pair or one quotient bit per step
    always_comb begin
        sq_trial = r_reg + bit_reg;
        rem_sh   = {rem_reg, x_reg[DIV_W-1]};
        div_ge   = (rem_sh >= {1'b0, d_reg});
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= (req.op == OP_SQRT) ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            op_reg  <= req.op;
            x_reg   <= op_a;
            r_reg   <= '0;
            bit_reg <= 64'd1 << 62;
            rem_reg <= '0;
            d_reg   <= op_b;
        end else if (busy_reg) begin
            case (op_reg)
                OP_SQRT: begin
                    if (x_reg >= sq_trial) begin
                        x_reg <= x_reg - sq_trial;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
                OP_DIV: begin
                    rem_reg <= div_ge ? DATA_W'(rem_sh - {1'b0, d_reg}) : rem_sh[DATA_W-1:0];
                    x_reg   <= x_reg << 1;
                    r_reg   <= {r_reg[62:0], div_ge};
                end
                default: begin
                    r_reg <= r_reg;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

    `SGS_ASSERT_IMPL(a_start_idle, aclk, aresetn, req.start, !busy_reg, "arith start while busy")
    `SGS_ASSERT_NEXT(a_done_pulse, aclk, aresetn, done_reg, !done_reg, "arith done held")
    `SGS_ASSERT_IMPL(a_div_nonzero, aclk, aresetn, req.start && req.op == OP_DIV,
                     op_b != '0, "division by zero")

endmodule

`default_nettype wire

// File: rtl/core/selective_gram_schmidt_top.sv
// Top level: load, selective Gram-Schmidt sequencer, result emission
//
//  channel | direction | fields                                         | handshake
//  s_      | in        | cov_value, adj_nonzero, row_index, col_index   | s_valid / s_ready
//  m_      | out       | out_value, out_row, out_col, last_out, degen.  | m_valid / m_ready
//  cfg_    | in        | wr_data (dim_in_use)                           | cfg_wr_en, no wait
//
// Load: one element per cycle unless cfg_wr_en is high, N*N transactions; s_ready is high only while loading.
// Compute per vector: copy, per earlier basis vector dot product and subtraction (shared
//   multiplier), squared norm, then unless zero root and normalise on the shared iterative divider, write.
// Emission: each result passes ST_OUT_A, ST_OUT_C, then waits in ST_OUT_W on m_ready; a new load starts after the last.
// Reset (aresetn, synchronous) restores N = DIM_MAX and clears the load position.
// Position comes from the arrival count; row_index and col_index are not used.
`default_nettype none
`include "selective_gram_schmidt_top_macros.svh"

module selective_gram_schmidt_top
    import sgs_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [DIM_W-1:0]          cfg_wr_data,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic signed [DATA_W-1:0]  s_cov_value,
    input  wire logic                      s_adj_nonzero,
    input  wire logic [IDX_W-1:0]          s_row_index,
    input  wire logic [IDX_W-1:0]          s_col_index,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [DATA_W-1:0]       m_out_value,
    output logic [IDX_W-1:0]               m_out_row,
    output logic [IDX_W-1:0]               m_out_col,
    output logic                           m_last_out,
    output logic                           m_degenerate
);

    typedef enum logic [21:0] {
        ST_LOAD  = 22'h000001,
        ST_ROW   = 22'h000002,
        ST_SEL   = 22'h000004,
        ST_CP_A  = 22'h000008,
        ST_CP_C  = 22'h000010,
        ST_PCHK  = 22'h000020,
        ST_DOT_A = 22'h000040,
        ST_DOT_B = 22'h000080,
        ST_DOT_C = 22'h000100,
        ST_PR_A  = 22'h000200,
        ST_PR_B  = 22'h000400,
        ST_PR_C  = 22'h000800,
        ST_SQ_A  = 22'h001000,
        ST_SQ_B  = 22'h002000,
        ST_ROOT  = 22'h004000,
        ST_ROOTW = 22'h008000,
        ST_DIV   = 22'h010000,
        ST_DIVW  = 22'h020000,
        ST_WR    = 22'h040000,
        ST_OUT_A = 22'h080000,
        ST_OUT_C = 22'h100000,
        ST_OUT_W = 22'h200000
    } state_t;

    state_t state_reg;

    logic [DIM_W-1:0] dim_reg;
    logic [IDX_W-1:0] n_m1;
    logic [IDX_W-1:0] lrow_reg, lcol_reg;
    logic [IDX_W-1:0] j_reg, i_reg, m_reg, b_reg, k_reg;
    logic [IDX_W-1:0] orow_reg, ocol_reg;
    logic [DIM_MAX*DIM_MAX-1:0] adj_reg;
    logic [DIM_MAX-1:0] deg_reg;
    logic signed [DATA_W-1:0] v_reg [DIM_MAX];
    logic signed [63:0] acc_reg;
    logic signed [DATA_W-1:0] dot_reg;
    logic [63:0] sq_reg;
    logic [DATA_W-1:0] mag_reg;
    logic zero_reg;
    logic neg_reg;

    logic m_valid_reg;
    logic signed [DATA_W-1:0] m_value_reg;
    logic [IDX_W-1:0] m_row_reg, m_col_reg;
    logic m_last_reg, m_deg_reg;

    // memories
    logic signed [DATA_W-1:0] rr_mem [2**ADDR_W];
    logic signed [DATA_W-1:0] bs_mem [2**ADDR_W];
    logic signed [DATA_W-1:0] rr_rd_reg, bs_rd_reg;
    logic rr_we;
    logic [ADDR_W-1:0] rr_waddr, rr_raddr, bs_waddr, bs_raddr;
    logic signed [DATA_W-1:0] rr_wdata;

    // shared units
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    arith_req_t arith_req;
    logic [63:0] arith_op_a;
    logic arith_done;
    logic [63:0] arith_res;

    logic signed [DATA_W-1:0] v_k;
    logic signed [DATA_W:0] v_ext, v_mag;
    logic signed [63:0] acc_next;
    logic [64:0] sq_sum;
    logic [63:0] sq_next;
    logic signed [65:0] q_signed;
    logic k_last, load_last, out_last;

    // effective dimension
    always_comb begin
        if (dim_reg == '0) begin
            n_m1 = '0;
        end else if (dim_reg > DIM_W'(DIM_MAX)) begin
            n_m1 = IDX_W'(DIM_MAX - 1);
        end else begin
            n_m1 = IDX_W'(dim_reg - DIM_W'(1));
        end
    end

    // datapath helpers
    always_comb begin
        v_k       = v_reg[k_reg];
        v_ext     = (DATA_W+1)'(v_k);
        v_mag     = v_k[DATA_W-1] ? -v_ext : v_ext;
        acc_next  = acc_reg + (mul_p >>> FRAC_BITS);
        sq_sum    = {1'b0, sq_reg} + {1'b0, mul_p[63:0]};
        sq_next   = sq_sum[64] ? '1 : sq_sum[63:0];
        q_signed  = neg_reg ? -signed'(66'(arith_res)) : signed'(66'(arith_res));
        k_last    = (k_reg == n_m1);
        load_last = (lrow_reg == n_m1) && (lcol_reg == n_m1);
        out_last  = (orow_reg == n_m1) && (ocol_reg == n_m1);
    end

    // memory ports and shared-unit operands
    always_comb begin
        rr_we      = ((state_reg == ST_LOAD) && s_valid && !cfg_wr_en)
                     || ((state_reg == ST_WR) && (i_reg == j_reg));
        rr_waddr   = (state_reg == ST_LOAD) ? {lrow_reg, lcol_reg} : {j_reg, k_reg};
        rr_wdata   = (state_reg == ST_LOAD) ? s_cov_value : v_k;
        rr_raddr   = (state_reg == ST_OUT_A) ? {orow_reg, ocol_reg} : {i_reg, k_reg};
        bs_waddr   = {m_reg, k_reg};
        bs_raddr   = {b_reg, k_reg};
        mul_a      = (state_reg == ST_PR_B) ? dot_reg : ((state_reg == ST_DOT_B) ? bs_rd_reg : v_k);
        mul_b      = (state_reg == ST_PR_B) ? bs_rd_reg : v_k;
        arith_req.start = (state_reg == ST_ROOT) || (state_reg == ST_DIV);
        arith_req.op    = (state_reg == ST_DIV) ? OP_DIV : OP_SQRT;
        arith_op_a = (state_reg == ST_DIV) ? ({32'd0, v_mag[DATA_W-1:0]} << FRAC_BITS) : sq_reg;
    end

    always_ff @(posedge aclk) begin
        if (rr_we) begin
            rr_mem[rr_waddr] <= rr_wdata;
        end
        rr_rd_reg <= rr_mem[rr_raddr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_WR) begin
            bs_mem[bs_waddr] <= v_k;
        end
        bs_rd_reg <= bs_mem[bs_raddr];
    end

    sgs_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    sgs_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (arith_req),
        .op_a    (arith_op_a),
        .op_b    (mag_reg),
        .done    (arith_done),
        .result  (arith_res)
    );

    // payload registers
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_LOAD) && s_valid && !cfg_wr_en) begin
            adj_reg[{lrow_reg, lcol_reg}] <= s_adj_nonzero;
        end
        unique case (state_reg)
            ST_CP_C:  v_reg[k_reg] <= rr_rd_reg;
            // accumulators start clean before every dot product and the norm
            ST_PCHK:  begin
                acc_reg <= '0;
                sq_reg  <= '0;
            end
            ST_DOT_C: begin
                acc_reg <= acc_next;
                dot_reg <= sat32(66'(acc_next));
            end
            ST_PR_C:  v_reg[k_reg] <= sat32(66'(v_k) - 66'(mul_p >>> FRAC_BITS));
            ST_SQ_B:  begin
                sq_reg   <= sq_next;
                zero_reg <= (sq_next == '0);
            end
            ST_ROOTW: mag_reg <= arith_res[DATA_W-1:0];
            ST_DIV:   neg_reg <= v_k[DATA_W-1];
            ST_DIVW:  if (arith_done) begin
                v_reg[k_reg] <= sat32(q_signed);
            end
            ST_OUT_C: begin
                m_value_reg <= rr_rd_reg;
                m_row_reg   <= orow_reg;
                m_col_reg   <= ocol_reg;
                m_last_reg  <= out_last;
                m_deg_reg   <= deg_reg[orow_reg];
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            dim_reg     <= DIM_W'(DIM_MAX);
            lrow_reg    <= '0;
            lcol_reg    <= '0;
            j_reg       <= '0;
            i_reg       <= '0;
            m_reg       <= '0;
            b_reg       <= '0;
            k_reg       <= '0;
            orow_reg    <= '0;
            ocol_reg    <= '0;
            deg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (cfg_wr_en) begin
                        dim_reg  <= cfg_wr_data;
                        lrow_reg <= '0;
                        lcol_reg <= '0;
                    end else if (s_valid) begin
                        if (load_last) begin
                            lrow_reg  <= '0;
                            lcol_reg  <= '0;
                            j_reg     <= '0;
                            state_reg <= ST_ROW;
                        end else if (lcol_reg == n_m1) begin
                            lcol_reg <= '0;
                            lrow_reg <= lrow_reg + IDX_W'(1);
                        end else begin
                            lcol_reg <= lcol_reg + IDX_W'(1);
                        end
                    end
                end
                ST_ROW: begin
                    i_reg     <= '0;
                    m_reg     <= '0;
                    state_reg <= ST_SEL;
                end
                // skip earlier rows that are adjacent to this one
                ST_SEL: begin
                    if ((i_reg != j_reg) && adj_reg[{j_reg, i_reg}]) begin
                        i_reg <= i_reg + IDX_W'(1);
                    end else begin
                        k_reg     <= '0;
                        state_reg <= ST_CP_A;
                    end
                end
                ST_CP_A: state_reg <= ST_CP_C;
                ST_CP_C: begin
                    k_reg <= k_last ? '0 : k_reg + IDX_W'(1);
                    if (k_last) begin
                        b_reg     <= '0;
                        state_reg <= ST_PCHK;
                    end else begin
                        state_reg <= ST_CP_A;
                    end
                end
                // project out each finished basis vector in turn
                ST_PCHK: begin
                    k_reg     <= '0;
                    state_reg <= (b_reg != m_reg) ? ST_DOT_A : ST_SQ_A;
                end
                ST_DOT_A: state_reg <= ST_DOT_B;
                ST_DOT_B: state_reg <= ST_DOT_C;
                ST_DOT_C: begin
                    k_reg     <= k_last ? '0 : k_reg + IDX_W'(1);
                    state_reg <= k_last ? ST_PR_A : ST_DOT_A;
                end
                ST_PR_A: state_reg <= ST_PR_B;
                ST_PR_B: state_reg <= ST_PR_C;
                ST_PR_C: begin
                    k_reg <= k_last ? '0 : k_reg + IDX_W'(1);
                    if (k_last) begin
                        b_reg     <= b_reg + IDX_W'(1);
                        state_reg <= ST_PCHK;
                    end else begin
                        state_reg <= ST_PR_A;
                    end
                end
                // squared norm
                ST_SQ_A: state_reg <= ST_SQ_B;
                ST_SQ_B: begin
                    k_reg <= k_last ? '0 : k_reg + IDX_W'(1);
                    if (k_last) begin
                        state_reg <= (sq_next == '0) ? ST_WR : ST_ROOT;
                    end else begin
                        state_reg <= ST_SQ_A;
                    end
                end
                ST_ROOT: state_reg <= ST_ROOTW;
                ST_ROOTW: begin
                    if (arith_done) begin
                        k_reg     <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: state_reg <= ST_DIVW;
                ST_DIVW: begin
                    if (arith_done) begin
                        k_reg     <= k_last ? '0 : k_reg + IDX_W'(1);
                        state_reg <= k_last ? ST_WR : ST_DIV;
                    end
                end
                // store the vector into the span, and into the row if it is the row itself
                ST_WR: begin
                    k_reg <= k_last ? '0 : k_reg + IDX_W'(1);
                    if (k_last) begin
                        if (i_reg == j_reg) begin
                            deg_reg[j_reg] <= zero_reg;
                            if (j_reg == n_m1) begin
                                orow_reg  <= '0;
                                ocol_reg  <= '0;
                                state_reg <= ST_OUT_A;
                            end else begin
                                j_reg     <= j_reg + IDX_W'(1);
                                state_reg <= ST_ROW;
                            end
                        end else begin
                            m_reg     <= m_reg + IDX_W'(1);
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= ST_SEL;
                        end
                    end
                end
                // emit results row-major
                ST_OUT_A: state_reg <= ST_OUT_C;
                ST_OUT_C: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_OUT_W;
                end
                ST_OUT_W: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (out_last) begin
                            state_reg <= ST_LOAD;
                        end else begin
                            if (ocol_reg == n_m1) begin
                                ocol_reg <= '0;
                                orow_reg <= orow_reg + IDX_W'(1);
                            end else begin
                                ocol_reg <= ocol_reg + IDX_W'(1);
                            end
                            state_reg <= ST_OUT_A;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    // a register write takes the load slot, so no transaction is taken alongside it
    assign s_ready      = (state_reg == ST_LOAD) && !cfg_wr_en;
    assign m_valid      = m_valid_reg;
    assign m_out_value  = m_value_reg;
    assign m_out_row    = m_row_reg;
    assign m_out_col    = m_col_reg;
    assign m_last_out   = m_last_reg;
    assign m_degenerate = m_deg_reg;

    `SGS_ASSERT_IMPL(a_no_overlap, aclk, aresetn, s_ready, !m_valid, "load while results pending")
    `SGS_ASSERT_NEXT(a_last_reload, aclk, aresetn, m_valid && m_ready && m_last_out,
                     state_reg == ST_LOAD, "no reload after last result")
    `SGS_ASSERT_IMPL(a_done_waiting, aclk, aresetn, arith_done,
                     state_reg == ST_ROOTW || state_reg == ST_DIVW, "arith result unexpected")

endmodule

`default_nettype wire
